// ===== hdl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned UNIT_W    = 16;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned POINT_W   = 21;
    localparam int unsigned PAIR_W    = 20;
    localparam int unsigned HALF_W    = 10;

    // Item queue between the front and back parts; depth is a power of two.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_W-1:0]  SURR_HIGH   = 16'hD800;
    localparam logic [UNIT_W-1:0]  SURR_LOW    = 16'hDC00;
    localparam logic [PAIR_W-1:0]  PAIR_OFFSET = 20'h10000;
    localparam logic [COUNT_W-1:0] COUNT_ONLY_LIMIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_SEQ     = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_UNIT = 2'd0,
        OP_PAIR = 2'd1,
        OP_END  = 2'd2
    } t_op_kind;

    // One work item for the back part: a single unit (data[15:0]), a pair
    // offset value (data[19:0]) or a string end with its count (data).
    typedef struct packed {
        t_op_kind           kind;
        logic               fail;
        logic [COUNT_W-1:0] data;
    } t_op_item;

endpackage

// ===== hdl/u8u16_front.sv =====
// Front part: accepts source bytes, decodes UTF-8 and queues work items.
module u8u16_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [u8u16_pkg::COUNT_W-1:0]       i_cfg_wdata,
    input  logic                                i_valid,
    input  logic [u8u16_pkg::BYTE_W-1:0]        i_byte,
    output logic                                o_ready,
    output logic                                o_push,
    output u8u16_pkg::t_op_item                 o_item,
    input  logic                                i_full
);
    import u8u16_pkg::*;

    t_phase               r_phase, n_phase;
    logic [1:0]           r_bytes_left, n_bytes_left;
    logic [POINT_W-1:0]   r_point, n_point;
    logic [COUNT_W-1:0]   r_units, n_units;
    logic [COUNT_W-1:0]   r_limit;
    logic                 r_writing;

    logic                 accept;
    logic [POINT_W-1:0]   cp_next;
    logic [1:0]           left_dec;
    logic [COUNT_W:0]     sum1;
    logic [COUNT_W:0]     sum2;
    logic                 no_room;
    logic                 no_pair_room;
    logic [PAIR_W-1:0]    pair_val;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Capacity 0 counts only; the limit is then the largest count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= COUNT_ONLY_LIMIT;
            r_writing <= 1'b0;
        end else if (i_cfg_we) begin
            r_limit   <= (i_cfg_wdata == '0) ? COUNT_ONLY_LIMIT : i_cfg_wdata;
            r_writing <= (i_cfg_wdata != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_bytes_left <= '0;
            r_point      <= '0;
            r_units      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_point      <= n_point;
            r_units      <= n_units;
        end
    end

    assign cp_next      = {r_point[POINT_W-7:0], i_byte[5:0]};
    assign left_dec     = r_bytes_left - 2'd1;
    assign sum1         = {1'b0, r_units} + {{COUNT_W{1'b0}}, 1'b1};
    assign sum2         = {1'b0, r_units} + {{(COUNT_W-1){1'b0}}, 2'd2};
    assign no_room      = sum1 >= {1'b0, r_limit};
    assign no_pair_room = sum2 >= {1'b0, r_limit};
    assign pair_val     = cp_next[PAIR_W-1:0] - PAIR_OFFSET;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_point      = r_point;
        n_units      = r_units;
        o_push       = 1'b0;
        o_item       = '{kind: OP_UNIT, fail: 1'b0, data: '0};
        if (accept) begin
            unique case (r_phase)
                PH_DISCARD: begin
                    if (i_byte == '0) begin
                        n_phase = PH_START;
                        n_units = '0;
                    end
                end
                PH_SEQ: begin
                    if (i_byte[7:6] != 2'b10) begin
                        o_push       = 1'b1;
                        o_item       = '{kind: OP_END, fail: 1'b1, data: '0};
                        n_phase      = (i_byte == '0) ? PH_START : PH_DISCARD;
                        n_bytes_left = '0;
                        n_point      = '0;
                        n_units      = '0;
                    end else if (left_dec != 2'd0) begin
                        n_point      = cp_next;
                        n_bytes_left = left_dec;
                    end else begin
                        n_phase      = PH_START;
                        n_bytes_left = '0;
                        n_point      = '0;
                        if (cp_next[POINT_W-1:UNIT_W] != '0) begin
                            if (no_pair_room) begin
                                o_push  = 1'b1;
                                o_item  = '{kind: OP_END, fail: 1'b1, data: '0};
                                n_phase = PH_DISCARD;
                                n_units = '0;
                            end else begin
                                o_push  = r_writing;
                                o_item  = '{kind: OP_PAIR, fail: 1'b0,
                                            data: {{(COUNT_W-PAIR_W){1'b0}}, pair_val}};
                                n_units = sum2[COUNT_W-1:0];
                            end
                        end else begin
                            o_push  = r_writing;
                            o_item  = '{kind: OP_UNIT, fail: 1'b0,
                                        data: {{(COUNT_W-UNIT_W){1'b0}},
                                               cp_next[UNIT_W-1:0]}};
                            n_units = sum1[COUNT_W-1:0];
                        end
                    end
                end
                PH_START: begin
                    if (i_byte == '0) begin
                        o_push  = 1'b1;
                        o_item  = '{kind: OP_END, fail: 1'b0, data: sum1[COUNT_W-1:0]};
                        n_units = '0;
                    end else if (no_room) begin
                        o_push  = 1'b1;
                        o_item  = '{kind: OP_END, fail: 1'b0, data: sum1[COUNT_W-1:0]};
                        n_phase = PH_DISCARD;
                        n_units = '0;
                    end else if (!i_byte[7]) begin
                        o_push  = r_writing;
                        o_item  = '{kind: OP_UNIT, fail: 1'b0,
                                    data: {{(COUNT_W-BYTE_W){1'b0}}, i_byte}};
                        n_units = sum1[COUNT_W-1:0];
                    end else if (i_byte[7:5] == 3'b110) begin
                        n_point      = {{(POINT_W-5){1'b0}}, i_byte[4:0]};
                        n_bytes_left = 2'd1;
                        n_phase      = PH_SEQ;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        n_point      = {{(POINT_W-4){1'b0}}, i_byte[3:0]};
                        n_bytes_left = 2'd2;
                        n_phase      = PH_SEQ;
                    end else if (i_byte[7:3] == 5'b11110) begin
                        n_point      = {{(POINT_W-3){1'b0}}, i_byte[2:0]};
                        n_bytes_left = 2'd3;
                        n_phase      = PH_SEQ;
                    end else begin
                        o_push  = 1'b1;
                        o_item  = '{kind: OP_END, fail: 1'b1, data: '0};
                        n_phase = PH_DISCARD;
                        n_units = '0;
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    a_seq_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SEQ |-> r_bytes_left != 2'd0)
        else $error("sequence phase with no continuation bytes left");

    a_discard_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DISCARD |-> r_units == '0)
        else $error("unit count not cleared while discarding");

endmodule

// ===== hdl/u8u16_queue.sv =====
// Short item queue between the decoding front and the output back part.
module u8u16_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  u8u16_pkg::t_op_item   i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output u8u16_pkg::t_op_item   o_item
);
    import u8u16_pkg::*;

    t_op_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("item pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ===== hdl/u8u16_back.sv =====
// Back part: turns queued items into output items, splitting surrogate pairs.
module u8u16_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  u8u16_pkg::t_op_item               i_q_item,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic [u8u16_pkg::UNIT_W-1:0]      o_code_unit,
    output logic                              o_last,
    output logic [u8u16_pkg::COUNT_W-1:0]     o_count,
    output logic                              o_failed,
    input  logic                              i_ready
);
    import u8u16_pkg::*;

    logic                 r_valid, n_valid;
    logic [UNIT_W-1:0]    r_code, n_code;
    logic                 r_last, n_last;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_failed, n_failed;
    logic                 r_pend, n_pend;
    logic [HALF_W-1:0]    r_low, n_low;

    logic                 load_ok;

    assign load_ok = !r_valid || i_ready;
    assign o_pop   = load_ok && !r_pend && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_last   <= n_last;
        r_count  <= n_count;
        r_failed <= n_failed;
        r_low    <= n_low;
    end

    always_comb begin
        n_valid  = r_valid;
        n_code   = r_code;
        n_last   = r_last;
        n_count  = r_count;
        n_failed = r_failed;
        n_pend   = r_pend;
        n_low    = r_low;
        if (load_ok) begin
            n_valid = 1'b0;
            if (r_pend) begin
                n_valid  = 1'b1;
                n_code   = SURR_LOW | {{(UNIT_W-HALF_W){1'b0}}, r_low};
                n_last   = 1'b0;
                n_count  = '0;
                n_failed = 1'b0;
                n_pend   = 1'b0;
            end else if (i_q_valid) begin
                n_valid = 1'b1;
                unique case (i_q_item.kind)
                    OP_UNIT: begin
                        n_code   = i_q_item.data[UNIT_W-1:0];
                        n_last   = 1'b0;
                        n_count  = '0;
                        n_failed = 1'b0;
                    end
                    OP_PAIR: begin
                        n_code   = SURR_HIGH | {{(UNIT_W-HALF_W){1'b0}},
                                                i_q_item.data[PAIR_W-1:HALF_W]};
                        n_last   = 1'b0;
                        n_count  = '0;
                        n_failed = 1'b0;
                        n_pend   = 1'b1;
                        n_low    = i_q_item.data[HALF_W-1:0];
                    end
                    OP_END: begin
                        n_code   = '0;
                        n_last   = 1'b1;
                        n_count  = i_q_item.data;
                        n_failed = i_q_item.fail;
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_code;
    assign o_last      = r_last;
    assign o_count     = r_count;
    assign o_failed    = r_failed;

    a_pend_behind_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && (r_code[UNIT_W-1:HALF_W] == SURR_HIGH[UNIT_W-1:HALF_W]))
        else $error("low surrogate pending without a high surrogate shown");

    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_pend) && $past(load_ok) |->
            r_valid && (r_code[UNIT_W-1:HALF_W] == SURR_LOW[UNIT_W-1:HALF_W]))
        else $error("high surrogate not followed by its low surrogate");

endmodule

// ===== hdl/utf8_to_utf16_transcoder_core.sv =====
// Top level of the UTF-8 to UTF-16 stream transcoder.
//
//  Channel   Dir  Handshake                 Content
//  -------   ---  ------------------------  ------------------------------------------
//  s (in)    in   i_s_tvalid / o_s_tready   tdata[7:0] = data_byte
//  m (out)   out  o_m_tvalid / i_m_tready   tdata[15:0] code_unit, [47:16] unit_count;
//                                           tlast end_of_string; tuser failed
//  cfg       in   i_cfg_we                  i_cfg_wdata = out_capacity
//
// Each source byte is accepted and decoded at once by the front part, so the
// input side runs at one byte per cycle while the queue has room.
// The back part delivers one output item per cycle while the output is ready;
// a code point above 0xFFFF becomes two output items (high then low surrogate).
// At the earliest, a byte's first result is loaded into the output register at
// the clock edge right after the one that accepts the byte. Reset is synchronous
// and active low; it clears the decoder state, the queue, the output valid flag
// and the pending low surrogate, and sets the capacity to count-only.
// A stall on the output side fills the four-entry queue before the input
// side stops taking bytes.
module utf8_to_utf16_transcoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: output capacity in code units, terminator included.
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // Source bytes.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    // UTF-16 results.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // [15:0] code_unit, [47:16] unit_count
    output logic        o_m_tlast,    // end_of_string
    output logic        o_m_tuser     // [0] failed
);
    import u8u16_pkg::*;

    // Front to queue.
    logic      front_push;
    t_op_item  front_item;
    logic      queue_full;

    // Queue to back.
    logic      queue_valid;
    t_op_item  queue_item;
    logic      back_pop;

    logic [UNIT_W-1:0]  out_code;
    logic [COUNT_W-1:0] out_count;

    // The front part holds all string state (phase, partial code point, unit
    // count and capacity), so every decision about truncation and errors is
    // made as the byte is accepted.
    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .o_ready     (o_s_tready),
        .o_push      (front_push),
        .o_item      (front_item),
        .i_full      (queue_full)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    // The back part owns the output register and expands surrogate pairs.
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (queue_valid),
        .i_q_item    (queue_item),
        .o_pop       (back_pop),
        .o_valid     (o_m_tvalid),
        .o_code_unit (out_code),
        .o_last      (o_m_tlast),
        .o_count     (out_count),
        .o_failed    (o_m_tuser),
        .i_ready     (i_m_tready)
    );

    assign o_m_tdata = {out_count, out_code};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 stream transcoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned TIMEOUT_NS = 5_000_000;

    // One UTF-16 result as it leaves the block.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
        logic [31:0] unit_count;
        logic        failed;
    } t_utf16_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    utf8_to_utf16_transcoder_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Source bytes waiting for the driver, and the random byte stream.
    logic [7:0]    src_pending[$];
    logic [7:0]    random_stream[$];
    t_utf16_result expected_results[$];
    int unsigned   failures = 0;

    // Shadow of the decoder state and of the capacity register.
    t_phase      dec_phase = PH_START;
    logic [1:0]  dec_left = '0;
    logic [20:0] dec_point = '0;
    logic [31:0] dec_units = '0;
    logic [31:0] cap_mirror = '0;

    function automatic void push_unit(input logic [15:0] unit);
        expected_results.push_back('{code_unit: unit, end_of_string: 1'b0,
                                     unit_count: 32'd0, failed: 1'b0});
    endfunction

    // Closes the current string. Without the zero byte seen, the rest of the
    // string up to its terminator is dropped.
    function automatic void close_string(input logic fail, input logic saw_zero);
        expected_results.push_back('{code_unit: 16'd0, end_of_string: 1'b1,
                                     unit_count: fail ? 32'd0 : dec_units + 32'd1,
                                     failed: fail});
        dec_units = '0;
        dec_left  = '0;
        dec_point = '0;
        dec_phase = saw_zero ? PH_START : PH_DISCARD;
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        logic [31:0] lim;
        logic [19:0] offs;
        lim = (cap_mirror == '0) ? COUNT_ONLY_LIMIT : cap_mirror;
        dec_phase = PH_START;
        dec_left  = '0;
        dec_point = '0;
        if (cp > 21'h00FFFF) begin
            offs = 20'(cp - 21'h010000);
            // A pair needs two free slots ahead of the terminator.
            if (64'(dec_units) + 64'd2 > 64'(lim) - 64'd1) begin
                close_string(1'b1, 1'b0);
                return;
            end
            if (cap_mirror != '0) begin
                push_unit(SURR_HIGH | 16'(offs[19:10]));
                push_unit(SURR_LOW | 16'(offs[9:0]));
            end
            dec_units += 32'd2;
        end else begin
            if (cap_mirror != '0) begin
                push_unit(cp[15:0]);
            end
            dec_units += 32'd1;
        end
    endfunction

    // Advances the shadow decoder by one accepted byte.
    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] lim;
        lim = (cap_mirror == '0) ? COUNT_ONLY_LIMIT : cap_mirror;
        case (dec_phase)
            PH_DISCARD: begin
                if (b == 8'h00) begin
                    dec_phase = PH_START;
                    dec_units = '0;
                end
            end
            PH_SEQ: begin
                if (b[7:6] != 2'b10) begin
                    close_string(1'b1, b == 8'h00);
                end else begin
                    dec_point = {dec_point[14:0], b[5:0]};
                    if (dec_left != '0) begin
                        dec_left -= 2'd1;
                    end
                    if (dec_left == '0) begin
                        emit_code_point(dec_point);
                    end
                end
            end
            default: begin
                if (b == 8'h00) begin
                    close_string(1'b0, 1'b1);
                end else if (dec_units >= lim - 32'd1) begin
                    close_string(1'b0, 1'b0);
                end else if (!b[7]) begin
                    emit_code_point({13'd0, b});
                end else if (b[7:5] == 3'b110) begin
                    dec_point = {16'd0, b[4:0]};
                    dec_left  = 2'd1;
                    dec_phase = PH_SEQ;
                end else if (b[7:4] == 4'b1110) begin
                    dec_point = {17'd0, b[3:0]};
                    dec_left  = 2'd2;
                    dec_phase = PH_SEQ;
                end else if (b[7:3] == 5'b11110) begin
                    dec_point = {18'd0, b[2:0]};
                    dec_left  = 2'd3;
                    dec_phase = PH_SEQ;
                end else begin
                    close_string(1'b1, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function automatic void check_result();
        t_utf16_result want;
        if (expected_results.size() == 0) begin
            failures++;
            $error("unexpected result: tdata 0x%0h tlast %0b tuser %0b",
                   m_tdata, m_tlast, m_tuser);
            return;
        end
        want = expected_results.pop_front();
        compare_field("code_unit", 32'(want.code_unit), 32'(m_tdata[15:0]));
        compare_field("unit_count", want.unit_count, m_tdata[47:16]);
        compare_field("end_of_string", 32'(want.end_of_string), 32'(m_tlast));
        compare_field("failed", 32'(want.failed), 32'(m_tuser));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Byte driver. The shadow decoder runs on every accepted item.
    int unsigned src_gap = 0;
    logic        src_burst = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (src_pending.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= src_pending.pop_front();
                    src_gap  <= src_burst ? 0 : pick_gap();
                    if ($urandom_range(0, 39) == 0) begin
                        src_burst <= !src_burst;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    int unsigned sink_stall = 0;
    logic        sink_burst = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!sink_burst && $urandom_range(0, 99) < 30) begin
                    sink_stall <= pick_gap();
                end
                if ($urandom_range(0, 49) == 0) begin
                    sink_burst <= !sink_burst;
                end
            end
        end
    end

    // Waits until every byte is in and every result is out, then lets the
    // pipeline settle so that bytes without results have been consumed too.
    task automatic drain();
        while (src_pending.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [31:0] value);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        cap_mirror = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Appends one character; a corrupted one gets a stray byte in front,
    // loses its last continuation byte, or has it replaced by any value.
    task automatic add_char(input logic corrupt);
        int unsigned kind;
        int unsigned ncont;
        int unsigned flaw;
        logic [7:0]  lead;
        kind = $urandom_range(1, 4);
        case (kind)
            1: begin
                lead  = 8'($urandom_range(1, 127));
                ncont = 0;
            end
            2: begin
                lead  = 8'hC0 | 8'($urandom_range(0, 31));
                ncont = 1;
            end
            3: begin
                lead  = 8'hE0 | 8'($urandom_range(0, 15));
                ncont = 2;
            end
            default: begin
                lead  = 8'hF0 | 8'($urandom_range(0, 7));
                ncont = 3;
            end
        endcase
        flaw = corrupt ? $urandom_range(0, 2) : 3;
        if (flaw == 0) begin
            random_stream.push_back(8'($urandom_range(0, 255)));
        end
        random_stream.push_back(lead);
        for (int unsigned k = 0; k < ncont; k++) begin
            if (flaw == 1 && k == ncont - 1) break;
            if (flaw == 2 && k == ncont - 1) begin
                random_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                random_stream.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end
    endtask

    initial begin
        int unsigned counted;
        int unsigned start;
        int unsigned nchars;
        int unsigned chunk;
        int unsigned chunk_idx;
        logic        broken;
        logic [31:0] cap;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty string, the largest value of each sequence length, then a bad
        // lead, a sequence cut by the terminator and a bad continuation byte.
        set_capacity(32'hFFFF_FFFF);
        src_pending = {src_pending, 8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'hFF, 8'h80, 8'h00,
                       8'hE2, 8'h00, 8'hC3, 8'h41, 8'h00};
        drain();
        // A surrogate pair with no room ahead of the terminator.
        set_capacity(32'd2);
        src_pending = {src_pending, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00};
        drain();
        // Capacity one leaves room for the terminator only: truncation at once.
        set_capacity(32'd1);
        src_pending = {src_pending, 8'h41, 8'h00};
        drain();

        // Random strings, mostly well formed, some broken, a little noise.
        counted = 0;
        while (counted < RANDOM_BYTES) begin
            broken = ($urandom_range(0, 99) < 20);
            nchars = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 24)
                                                  : $urandom_range(0, 8);
            start = random_stream.size();
            for (int unsigned c = 0; c < nchars; c++) begin
                add_char(broken && $urandom_range(0, 3) == 0);
            end
            random_stream.push_back(8'h00);
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    random_stream.push_back(8'($urandom_range(0, 255)));
                end
            end
            counted += random_stream.size() - start;
        end

        // Feed the stream in chunks that may end mid-string, with a new
        // capacity for each chunk.
        chunk_idx = 0;
        while (random_stream.size() != 0) begin
            case (chunk_idx)
                0: cap = 32'd0;
                1: cap = 32'hFFFF_FFFF;
                default: begin
                    case ($urandom_range(0, 7))
                        0: cap = 32'd0;
                        1: cap = 32'd1;
                        2: cap = 32'd2;
                        3: cap = 32'($urandom_range(3, 6));
                        4: cap = 32'($urandom_range(7, 20));
                        5: cap = 32'hFFFF_FFFF;
                        6: cap = 32'hFFFF_FFFE;
                        default: cap = $urandom;
                    endcase
                end
            endcase
            set_capacity(cap);
            chunk = $urandom_range(30, 160);
            while (chunk != 0 && random_stream.size() != 0) begin
                src_pending.push_back(random_stream.pop_front());
                chunk--;
            end
            drain();
            chunk_idx++;
        end

        if (failures == 0) begin
            $display("PASS utf8_to_utf16_transcoder_core");
        end else begin
            $display("FAIL utf8_to_utf16_transcoder_core");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL utf8_to_utf16_transcoder_core");
        $finish;
    end

endmodule
